/* rtl/cri_pkg.sv */
// Types, codes and constants shared by the color ramp interpolator.
// No dependencies; imported by every other file of the block.
package cri_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Status codes of a result word
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Shared divider geometry: full mode walks all dividend bits,
    // short mode only the low quotient bits (quotient known below 256).
    localparam int DEN_W = 16;
    localparam int QS_W  = 8;
    localparam int DIV_W = DEN_W + QS_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] point_position;
        logic [7:0]  point_red;
        logic [7:0]  point_green;
        logic [7:0]  point_blue;
        logic [7:0]  entry_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_word;

    // One stored control point
    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_point;

    typedef struct packed {
        logic             start;
        logic             short_mode;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    // Channel select: 0 red, 1 green, 2 blue
    function automatic logic [7:0] point_chan(input t_point pt, input logic [1:0] ch);
        logic [7:0] val;
        case (ch)
            2'd0:    val = pt.red;
            2'd1:    val = pt.green;
            default: val = pt.blue;
        endcase
        return val;
    endfunction

endpackage

/* rtl/cri_store.sv */
// Control point store: one synchronous memory, one write and one read port.
// Read data is registered. Uses cri_pkg.
module cri_store
    import cri_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_point        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_point        o_rdata
);

    t_point r_mem [DEPTH];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cri_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Full mode: DIV_W steps. Short mode: QS_W steps, quotient must fit QS_W bits.
// Uses cri_pkg.
module cri_div
    import cri_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_div;
    logic [DIV_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // remainder stays below the divisor, so the trial fits DEN_W+1 bits
    assign trial = {r_rem, r_q[DIV_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
            if (i_req.short_mode) begin
                r_rem <= i_req.dividend[DIV_W-1 -: DEN_W];
                r_q   <= {i_req.dividend[QS_W-1:0], {DEN_W{1'b0}}};
            end else begin
                r_rem <= '0;
                r_q   <= i_req.dividend;
            end
        end else if (r_run) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= i_req.short_mode ? CNT_W'(QS_W) : CNT_W'(DIV_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/color_ramp_interpolator.sv */
// Color ramp interpolator: sorted control point store with linear lookup.
// Clear, an unused op, an add to a full store and a lookup in an empty store are answered
// from idle; an add moves each stored point above the new one up an entry, then writes it in.
// Lookup checks the first point, then the last, then scans up to MAX_POINTS - 1 points for
// the enclosing segment and runs 3 channels, each a multiply and an 8-step divide.
// One word at a time, busy high while working; results cannot be stalled; reset empties store.
module color_ramp_interpolator
    import cri_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int ENTRIES    = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd,
    output logic      o_done,
    output t_out_word o_result
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;  // read the point below the hole, or drop new point in at entry 0
    localparam logic [3:0] S_INS_CMP = 4'd2;  // move it up or drop new point in
    localparam logic [3:0] S_CHK0    = 4'd4;  // first point check
    localparam logic [3:0] S_CHKL    = 4'd5;  // last point check
    localparam logic [3:0] S_SCAN    = 4'd6;  // walk to the enclosing segment
    localparam logic [3:0] S_MUL0    = 4'd7;  // c0 * (x1 - p)
    localparam logic [3:0] S_MUL1    = 4'd8;  // + c1 * (p - x0), start divide
    localparam logic [3:0] S_DIV     = 4'd9;  // wait for channel quotient

    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_k, n_k;
    logic [AW-1:0]    r_j, n_j;
    t_point           r_new, n_new;
    logic [15:0]      r_p, n_p;
    t_point           r_lo, n_lo;      // segment start (x0, c0)
    t_point           r_hi, n_hi;      // segment end color
    logic [15:0]      r_d0, n_d0;
    logic [15:0]      r_d1, n_d1;
    logic [15:0]      r_den, n_den;
    logic [DIV_W-1:0] r_prod, n_prod;
    logic [1:0]       r_ch, n_ch;
    logic [7:0]       r_red, n_red;
    logic [7:0]       r_grn, n_grn;
    logic             r_done, n_done;
    t_out_word        r_result, n_result;

    logic             accept;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_point           mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    t_point           mem_rdata;
    t_div_req         div_req;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [AW-1:0]    last_idx;
    logic [15:0]      pos_tbl [256];

    assign busy     = (r_state != S_IDLE);
    assign accept   = start & ~busy;
    assign last_idx = AW'(r_count - 1'b1);

    // index to position, floor(index * 65535 / (ENTRIES - 1)) saturated to 16 bits;
    // every entry is a constant, so this is plain logic
    for (genvar gi = 0; gi < 256; gi++) begin : g_pos_tbl
        localparam int PW = gi * 65535 / (ENTRIES - 1);
        assign pos_tbl[gi] = (PW > 65535) ? 16'hFFFF : 16'(PW);
    end

    cri_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_j      = r_j;
        n_new    = r_new;
        n_p      = r_p;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_d0     = r_d0;
        n_d1     = r_d1;
        n_den    = r_den;
        n_prod   = r_prod;
        n_ch     = r_ch;
        n_red    = r_red;
        n_grn    = r_grn;
        n_done   = 1'b0;
        n_result = r_result;

        mem_we    = 1'b0;
        mem_waddr = r_k;
        mem_wdata = r_new;
        mem_re    = 1'b0;
        mem_raddr = '0;

        div_req            = '0;
        div_req.short_mode = 1'b1;
        div_req.divisor    = r_den;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_done   = 1'b1;
                            n_result = '{status: ST_OK, default: '0};
                        end
                        OP_ADD: begin
                            if (r_count == CW'(MAX_POINTS)) begin
                                n_done   = 1'b1;
                                n_result = '{status: ST_FULL, default: '0};
                            end else begin
                                n_new.pos   = i_cmd.point_position;
                                n_new.red   = i_cmd.point_red;
                                n_new.green = i_cmd.point_green;
                                n_new.blue  = i_cmd.point_blue;
                                n_k         = AW'(r_count);
                                n_state     = S_INS_RD;
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_result = '{status: ST_EMPTY, default: '0};
                            end else begin
                                n_p       = pos_tbl[i_cmd.entry_index];
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_state   = S_CHK0;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{status: ST_OK, default: '0};
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                if (r_k == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    n_count   = r_count + 1'b1;
                    n_done    = 1'b1;
                    n_result  = '{status: ST_OK, default: '0};
                    n_state   = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k - 1'b1;
                    n_state   = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                mem_we = 1'b1;
                // strictly greater moves up, so ties keep arrival order
                if (mem_rdata.pos > r_new.pos) begin
                    mem_wdata = mem_rdata;
                    n_k       = r_k - 1'b1;
                    n_state   = S_INS_RD;
                end else begin
                    n_count  = r_count + 1'b1;
                    n_done   = 1'b1;
                    n_result = '{status: ST_OK, default: '0};
                    n_state  = S_IDLE;
                end
            end

            S_CHK0: begin
                if (r_p <= mem_rdata.pos) begin
                    n_done   = 1'b1;
                    n_result = '{ST_OK, mem_rdata.red, mem_rdata.green, mem_rdata.blue};
                    n_state  = S_IDLE;
                end else begin
                    n_lo      = mem_rdata;
                    mem_re    = 1'b1;
                    mem_raddr = last_idx;
                    n_state   = S_CHKL;
                end
            end

            S_CHKL: begin
                if (r_p >= mem_rdata.pos) begin
                    n_done   = 1'b1;
                    n_result = '{ST_OK, mem_rdata.red, mem_rdata.green, mem_rdata.blue};
                    n_state  = S_IDLE;
                end else begin
                    // p lies strictly inside, so at least two points are stored
                    mem_re    = 1'b1;
                    mem_raddr = AW'(1);
                    n_j       = AW'(1);
                    n_state   = S_SCAN;
                end
            end

            S_SCAN: begin
                // first point at or above p closes the segment; its start is
                // strictly below p, so the segment width is never zero here
                if (r_p <= mem_rdata.pos) begin
                    n_hi    = mem_rdata;
                    n_d0    = mem_rdata.pos - r_p;
                    n_d1    = r_p - r_lo.pos;
                    n_den   = mem_rdata.pos - r_lo.pos;
                    n_ch    = 2'd0;
                    n_state = S_MUL0;
                end else begin
                    n_lo      = mem_rdata;
                    n_j       = r_j + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = r_j + 1'b1;
                end
            end

            S_MUL0: begin
                n_prod  = DIV_W'(point_chan(r_lo, r_ch)) * DIV_W'(r_d0);
                n_state = S_MUL1;
            end

            S_MUL1: begin
                // blended sum is at most 255 * width, quotient fits 8 bits
                div_req.start    = 1'b1;
                div_req.dividend = r_prod + DIV_W'(point_chan(r_hi, r_ch)) * DIV_W'(r_d1);
                n_state          = S_DIV;
            end

            S_DIV: begin
                if (div_done) begin
                    case (r_ch)
                        2'd0: begin
                            n_red   = div_quot[7:0];
                            n_ch    = 2'd1;
                            n_state = S_MUL0;
                        end
                        2'd1: begin
                            n_grn   = div_quot[7:0];
                            n_ch    = 2'd2;
                            n_state = S_MUL0;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{ST_OK, r_red, r_grn, div_quot[7:0]};
                            n_state  = S_IDLE;
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_j      <= n_j;
        r_new    <= n_new;
        r_p      <= n_p;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_d0     <= n_d0;
        r_d1     <= n_d1;
        r_den    <= n_den;
        r_prod   <= n_prod;
        r_ch     <= n_ch;
        r_red    <= n_red;
        r_grn    <= n_grn;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> r_count == CW'(MAX_POINTS))
        else $error("full status with room left");

    a_error_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
        (o_result.out_red == 8'd0 && o_result.out_green == 8'd0 &&
         o_result.out_blue == 8'd0))
        else $error("nonzero color on error status");

    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished with nobody waiting");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j <= last_idx))
        else $error("segment scan ran past the last point");

endmodule

/* dv/color_ramp_checker.sv */
// Result checker for the color ramp interpolator: tracks the point store,
// predicts each answer word and compares it with what the block returns.
// Depends on cri_pkg for the word and point types and the op/status codes.
module color_ramp_checker
    import cri_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int ENTRIES    = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_word  i_cmd,
    input  logic      i_done,
    input  t_out_word i_result,
    output int        o_fail_count,
    output int        o_pending
);

    t_point    ramp_pts [MAX_POINTS];
    int        ramp_count = 0;
    t_out_word awaited_words [$];
    t_out_word due_word;
    int        fail_count = 0;
    int        pending_words = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_words;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [7:0] mix_channel(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [15:0] x0, input logic [15:0] x1,
                                               input logic [15:0] p);
        logic [31:0] num;
        logic [31:0] span;
        // zero-width segment falls back to the left color
        if (x1 <= x0) begin
            return c0;
        end
        span = 32'(x1) - 32'(x0);
        num  = 32'(c0) * (32'(x1) - 32'(p)) + 32'(c1) * (32'(p) - 32'(x0));
        return 8'(num / span);
    endfunction

    // Apply one input word to the tracked store and return its answer word.
    function automatic t_out_word predict_answer(input t_in_word w);
        t_out_word   ans;
        int          k;
        int          last;
        logic [31:0] pw;
        logic [15:0] p;
        logic [15:0] x0;
        logic [15:0] x1;
        bit          found;
        ans   = '0;
        found = 1'b0;
        case (w.op)
            OP_CLEAR: begin
                ramp_count = 0;
            end
            OP_ADD: begin
                if (ramp_count >= MAX_POINTS) begin
                    ans.status = ST_FULL;
                end else begin
                    // insert after every point at or below the new position
                    k = ramp_count;
                    while (k > 0 && ramp_pts[k-1].pos > w.point_position) begin
                        ramp_pts[k] = ramp_pts[k-1];
                        k--;
                    end
                    ramp_pts[k].pos   = w.point_position;
                    ramp_pts[k].red   = w.point_red;
                    ramp_pts[k].green = w.point_green;
                    ramp_pts[k].blue  = w.point_blue;
                    ramp_count++;
                end
            end
            OP_LOOKUP: begin
                if (ramp_count == 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    pw   = 32'(w.entry_index) * 32'd65535 / 32'(ENTRIES - 1);
                    p    = (pw > 32'd65535) ? 16'hFFFF : pw[15:0];
                    last = ramp_count - 1;
                    if (p <= ramp_pts[0].pos) begin
                        ans.out_red   = ramp_pts[0].red;
                        ans.out_green = ramp_pts[0].green;
                        ans.out_blue  = ramp_pts[0].blue;
                    end else if (p >= ramp_pts[last].pos) begin
                        ans.out_red   = ramp_pts[last].red;
                        ans.out_green = ramp_pts[last].green;
                        ans.out_blue  = ramp_pts[last].blue;
                    end else begin
                        for (k = 0; k < last && !found; k++) begin
                            x0 = ramp_pts[k].pos;
                            x1 = ramp_pts[k+1].pos;
                            if (p >= x0 && p <= x1) begin
                                found = 1'b1;
                                ans.out_red   = mix_channel(ramp_pts[k].red,
                                                            ramp_pts[k+1].red, x0, x1, p);
                                ans.out_green = mix_channel(ramp_pts[k].green,
                                                            ramp_pts[k+1].green, x0, x1, p);
                                ans.out_blue  = mix_channel(ramp_pts[k].blue,
                                                            ramp_pts[k+1].blue, x0, x1, p);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ramp_count = 0;
        end else begin
            if (i_start && !i_busy) begin
                awaited_words = {awaited_words, predict_answer(i_cmd)};
            end
            if (i_done) begin
                if (awaited_words.size() == 0) begin
                    report_mismatch("answer word with none pending", i_result, -1);
                end else begin
                    due_word = awaited_words.pop_front();
                    if (i_result.status !== due_word.status)
                        report_mismatch("status", i_result.status, due_word.status);
                    if (i_result.out_red !== due_word.out_red)
                        report_mismatch("red", i_result.out_red, due_word.out_red);
                    if (i_result.out_green !== due_word.out_green)
                        report_mismatch("green", i_result.out_green, due_word.out_green);
                    if (i_result.out_blue !== due_word.out_blue)
                        report_mismatch("blue", i_result.out_blue, due_word.out_blue);
                end
            end
        end
        pending_words = awaited_words.size();
    end

endmodule

/* dv/color_ramp_interpolator_tb.sv */
// Testbench top for the color ramp interpolator: clock, reset and command words.
// Depends on cri_pkg, the block and color_ramp_checker, which predicts and compares.
module color_ramp_interpolator_tb;
    import cri_pkg::*;

    localparam int MAX_PTS      = 16;
    localparam int TBL_ENTRIES  = 256;
    localparam int RANDOM_WORDS = 1900;
    // final stretch runs back to back, no sender gaps
    localparam int QUIET_TAIL   = 200;
    // op code the block does not define; it must answer ok with zero colors
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_word  i_cmd   = '0;
    logic      o_done;
    t_out_word o_result;

    int fail_count;
    int pending_words;
    int sent_words = 0;
    bit quiet      = 1'b0;
    bit gaps_on    = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    color_ramp_interpolator #(
        .MAX_POINTS(MAX_PTS),
        .ENTRIES   (TBL_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    color_ramp_checker #(
        .MAX_POINTS(MAX_PTS),
        .ENTRIES   (TBL_ENTRIES)
    ) ramp_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (i_cmd),
        .i_done      (o_done),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending_words)
    );

    // Every field random, so bits the op does not use still toggle.
    function automatic t_in_word any_word(input logic [1:0] op);
        t_in_word w;
        w.op             = op;
        w.point_position = 16'($urandom_range(0, 65535));
        w.point_red      = 8'($urandom_range(0, 255));
        w.point_green    = 8'($urandom_range(0, 255));
        w.point_blue     = 8'($urandom_range(0, 255));
        w.entry_index    = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic t_in_word add_word(input logic [15:0] pos, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
        t_in_word w;
        w                = any_word(OP_ADD);
        w.point_position = pos;
        w.point_red      = r;
        w.point_green    = g;
        w.point_blue     = b;
        return w;
    endfunction

    function automatic t_in_word lookup_word(input logic [7:0] idx);
        t_in_word w;
        w             = any_word(OP_LOOKUP);
        w.entry_index = idx;
        return w;
    endfunction

    // Position patterns for a ramp being built:
    //   0 anywhere, 1 exactly on table positions (index*257),
    //   2 a handful of values so ties pile up, 3 falling, so each add shifts the store.
    function automatic logic [15:0] pick_position(input int style, input int n);
        logic [15:0] pos;
        case (style)
            0: pos = 16'($urandom_range(0, 65535));
            1: pos = 16'($urandom_range(0, 255) * 257);
            2: begin
                case ($urandom_range(0, 3))
                    0:       pos = 16'h0000;
                    1:       pos = 16'hFFFF;
                    2:       pos = 16'h8000;
                    default: pos = 16'h7FFF;
                endcase
            end
            default: pos = 16'(65535 - n * 3400 - $urandom_range(0, 300));
        endcase
        return pos;
    endfunction

    // Present a word and hold it until the block takes it. busy is sampled on the
    // falling edge, where it is stable, so the accepting rising edge is known
    // without racing the block's own updates.
    task automatic send_word(input t_in_word w);
        start <= 1'b1;
        i_cmd <= w;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        if (w.op != OP_SPARE) sent_words++;
    endtask

    // Sender gap: a burst of idle cycles, either right after the last accept
    // (block still working) or once the block has gone idle.
    task automatic issue(input t_in_word w);
        if (!quiet && gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                @(negedge i_clk);
                while (busy) @(negedge i_clk);
                @(posedge i_clk);
            end
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        send_word(w);
    endtask

    task automatic run_directed();
        // empty store: lookup reports empty, spare op and clear answer ok
        issue(lookup_word(8'd255));
        issue(any_word(OP_SPARE));
        issue(any_word(OP_CLEAR));
        // end points added out of order so the second add shifts the first
        issue(add_word(16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        issue(add_word(16'h0000, 8'h00, 8'h00, 8'h00));
        issue(lookup_word(8'd0));
        issue(lookup_word(8'd255));
        issue(lookup_word(8'd128));
        issue(lookup_word(8'd1));
        // two points on the same position: arrival order kept
        issue(add_word(16'd2570, 8'h12, 8'h34, 8'h56));
        issue(add_word(16'd2570, 8'hA5, 8'h5A, 8'hC3));
        issue(lookup_word(8'd10));
        issue(lookup_word(8'd11));
        issue(lookup_word(8'd9));
        // single point: same color on both sides of it
        issue(any_word(OP_CLEAR));
        issue(add_word(16'h8000, 8'h80, 8'h7F, 8'h01));
        issue(lookup_word(8'd0));
        issue(lookup_word(8'd255));
        issue(lookup_word(8'd128));
        issue(lookup_word(8'd127));
    endtask

    task automatic run_random();
        int style;
        int n_adds;
        int n_looks;
        int i;
        logic [7:0] idx;
        sent_words = 0;
        while (sent_words < RANDOM_WORDS) begin
            quiet = (sent_words >= RANDOM_WORDS - QUIET_TAIL);
            if ($urandom_range(0, 4) == 0) gaps_on = !gaps_on;
            if ($urandom_range(0, 9) < 7) begin
                // build a ramp, then read it back; skipping the clear stacks
                // points onto the old ramp and reaches the full store
                if ($urandom_range(0, 4) != 0) issue(any_word(OP_CLEAR));
                style  = $urandom_range(0, 3);
                n_adds = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_PTS, MAX_PTS + 3)
                                                     : $urandom_range(1, 8);
                for (i = 0; i < n_adds; i++) begin
                    issue(add_word(pick_position(style, i), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
                end
                n_looks = $urandom_range(1, 12);
                for (i = 0; i < n_looks; i++) begin
                    case ($urandom_range(0, 7))
                        0:       idx = 8'd0;
                        1:       idx = 8'd255;
                        default: idx = 8'($urandom_range(0, 255));
                    endcase
                    issue(lookup_word(idx));
                end
            end else begin
                // noise: any op, any field
                n_adds = $urandom_range(1, 8);
                for (i = 0; i < n_adds; i++) begin
                    issue(any_word(2'($urandom_range(0, 3))));
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();

        // drain: every answer word in, then a tail for stray strobes
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_words != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
